// ----- sv/kss_pkg.sv -----
// -----------------------------------------------------------------------------
// kss_pkg
// Shared widths, default sizes and codes of the trimmed k-th smallest select.
// -----------------------------------------------------------------------------
package kss_pkg;

	localparam int DEFAULT_MAX_ENTRIES = 64;
	localparam int DEFAULT_MAX_DIGITS  = 16;

	localparam int CMD_W    = 1;
	localparam int SLOT_W   = 6;
	localparam int BCD_W    = 64;
	localparam int RANK_W   = 7;
	localparam int TRIM_W   = 5;
	localparam int STATUS_W = 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 1'b0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_LENGTH = 2'd1;

	localparam logic [RANK_W-1:0] RESET_ENTRY_COUNT  = 7'd1;
	localparam logic [TRIM_W-1:0] RESET_DIGIT_LENGTH = 5'd16;

endpackage

// ----- sv/kss_if.sv -----
// -----------------------------------------------------------------------------
// kss_if
// Valid/ready channels of the trimmed k-th smallest select: request,
// response and register write.
// -----------------------------------------------------------------------------
interface kss_req_if;
	import kss_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [SLOT_W-1:0] entry_index;
	logic [BCD_W-1:0]  bcd_digits;
	logic [RANK_W-1:0] rank_k;
	logic [TRIM_W-1:0] trim_width;

	modport source (output valid, cmd, entry_index, bcd_digits, rank_k, trim_width,
		input ready);
	modport sink (input valid, cmd, entry_index, bcd_digits, rank_k, trim_width,
		output ready);
endinterface

interface kss_rsp_if;
	import kss_pkg::*;

	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   found_index;
	logic [STATUS_W-1:0] status;

	modport source (output valid, found_index, status, input ready);
	modport sink (input valid, found_index, status, output ready);
endinterface

interface kss_cfg_if;
	import kss_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/kss_ram.sv -----
// -----------------------------------------------------------------------------
// kss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// -----------------------------------------------------------------------------
module kss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/kth_smallest_trimmed_select.sv -----
// -----------------------------------------------------------------------------
// kth_smallest_trimmed_select
// Table of BCD numbers; a query returns the index of the entry of rank k by
// the value of its rightmost trim digits, ties to the lower index.
// -----------------------------------------------------------------------------
// Usage:
//   req  : one word per item. cmd load writes bcd_digits to slot entry_index
//          (slots at or above MAX_ENTRIES are dropped) and gives no response.
//          cmd query asks for rank rank_k over trim_width trailing digits.
//   rsp  : one word per query: found_index and status (ok or out of range).
//   cfg  : register writes, index 0 entry_count, index 1 digit_length; always
//          ready; written only while block is idle by user rule, unchecked.
//   Scan: a valid query visits entries in index order; for each visited
//   entry, one read port of the table RAM streams all entries past one
//   comparator. An out of range query answers without a scan.
//   req is taken only while no query is in work; a finished result moves to
//   the output register, so a stalled rsp holds only that register and the
//   next word is taken. A second result waits until rsp drains.
//   Reset: entry_count 1, digit_length 16, no response pending. Table
//   contents are undefined until loaded.
// -----------------------------------------------------------------------------
module kth_smallest_trimmed_select #(
	parameter int MAX_ENTRIES = kss_pkg::DEFAULT_MAX_ENTRIES,
	parameter int MAX_DIGITS  = kss_pkg::DEFAULT_MAX_DIGITS
) (
	input  logic      clk,
	input  logic      arst_n,
	kss_cfg_if.sink   cfg,
	kss_req_if.sink   req,
	kss_rsp_if.source rsp
);
	import kss_pkg::*;

	localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int DW     = 4 * MAX_DIGITS;
	localparam int CNT_B  = $clog2(MAX_ENTRIES + 1);
	localparam int CNT_W  = (CNT_B > RANK_W) ? CNT_B : RANK_W;
	localparam logic [CNT_W-1:0]  MAX_ENT_C = CNT_W'(MAX_ENTRIES);
	localparam logic [TRIM_W-1:0] MAX_DIG_C = TRIM_W'(MAX_DIGITS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RDI  = 5'b00010,
		S_CAPI = 5'b00100,
		S_SCAN = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [RANK_W-1:0]    entry_count_q;
	logic [TRIM_W-1:0]    digit_length_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     k_m1_q;
	logic [DW-1:0]        mask_q;
	logic [DW-1:0]        vi_q;
	logic [CNT_W-1:0]     i_q;
	logic [CNT_W-1:0]     j_q;
	logic [CNT_W-1:0]     j_s1;
	logic                 rd_v_s1;
	logic [CNT_W-1:0]     rank_q;
	logic [SLOT_W-1:0]    res_idx_q;
	logic [STATUS_W-1:0]  res_st_q;
	logic                 out_valid_q;
	logic [SLOT_W-1:0]    found_q;
	logic [STATUS_W-1:0]  status_q;

	logic [CNT_W-1:0]  count_w;
	logic [CNT_W-1:0]  rank_k_w;
	logic [TRIM_W-1:0] dlen_w;
	logic [DW-1:0]     mask_w;
	logic              range_err;
	logic              slot_ok;
	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	logic [DW-1:0]     ram_rdata;
	logic [DW-1:0]     vj;
	logic              ahead;

	always_comb begin
		count_w  = (CNT_W'(entry_count_q) > MAX_ENT_C) ? MAX_ENT_C : CNT_W'(entry_count_q);
		dlen_w   = (digit_length_q > MAX_DIG_C) ? MAX_DIG_C : digit_length_q;
		rank_k_w = CNT_W'(req.rank_k);
		for (int d = 0; d < MAX_DIGITS; d++) begin
			mask_w[d*4 +: 4] = (TRIM_W'(d) < req.trim_width) ? 4'hF : 4'h0;
		end
		range_err = (rank_k_w == '0) || (rank_k_w > count_w) ||
			(req.trim_width == '0) || (req.trim_width > dlen_w);
		slot_ok   = CNT_W'(req.entry_index) < MAX_ENT_C;
		ram_we    = (state_q == S_IDLE) && req.valid && (req.cmd == CMD_LOAD) && slot_ok;
		ram_raddr = (state_q == S_RDI) ? i_q[AW-1:0] : j_q[AW-1:0];
		vj        = ram_rdata & mask_q;
		ahead     = (vj < vi_q) || ((vj == vi_q) && (j_s1 < i_q));
	end

	kss_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(req.entry_index)),
		.wdata(req.bcd_digits[DW-1:0]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg.ready       = 1'b1;
	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.found_index = found_q;
	assign rsp.status      = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			entry_count_q  <= RESET_ENTRY_COUNT;
			digit_length_q <= RESET_DIGIT_LENGTH;
			out_valid_q    <= 1'b0;
			rd_v_s1        <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_ENTRY_COUNT:  entry_count_q  <= cfg.data;
					CFG_DIGIT_LENGTH: digit_length_q <= cfg.data[TRIM_W-1:0];
					default: ;
				endcase
			end
			if (rsp.ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && (req.cmd == CMD_QUERY)) begin
						count_q <= count_w;
						k_m1_q  <= rank_k_w - CNT_W'(1);
						mask_q  <= mask_w;
						i_q     <= '0;
						j_q     <= '0;
						if (range_err) begin
							res_idx_q <= '0;
							res_st_q  <= ST_RANGE;
							state_q   <= S_FIN;
						end else begin
							state_q <= S_RDI;
						end
					end
				end
				S_RDI: begin
					state_q <= S_CAPI;
				end
				S_CAPI: begin
					vi_q    <= ram_rdata & mask_q;
					rank_q  <= '0;
					rd_v_s1 <= 1'b1;
					j_s1    <= j_q;
					j_q     <= j_q + CNT_W'(1);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (rd_v_s1) begin
						if (ahead) begin
							rank_q <= rank_q + CNT_W'(1);
						end
						if (j_q < count_q) begin
							j_s1 <= j_q;
							j_q  <= j_q + CNT_W'(1);
						end else begin
							rd_v_s1 <= 1'b0;
						end
					end else if (rank_q == k_m1_q) begin
						res_idx_q <= i_q[SLOT_W-1:0];
						res_st_q  <= ST_OK;
						state_q   <= S_FIN;
					end else if ((i_q + CNT_W'(1)) < count_q) begin
						i_q     <= i_q + CNT_W'(1);
						j_q     <= '0;
						state_q <= S_RDI;
					end else begin
						res_idx_q <= '0;
						res_st_q  <= ST_RANGE;
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						found_q     <= res_idx_q;
						status_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/kss_rank_checker.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// kss_rank_checker
// Watches the register, request and response channels of the trimmed k-th
// smallest select, keeps its own copy of the table and registers, works out
// the answer of every accepted query and compares each response word with the
// oldest answer owed.
// -----------------------------------------------------------------------------
module kss_rank_checker (
	input  logic clk,
	input  logic arst_n,
	kss_cfg_if   cfg,
	kss_req_if   req,
	kss_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	import kss_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]   found_index;
		logic [STATUS_W-1:0] status;
	} rank_answer_t;

	rank_answer_t            owed_answers[$];
	logic [BCD_W-1:0]        slot_word [DEFAULT_MAX_ENTRIES];
	logic [CFG_DATA_W-1:0]   entry_limit = RESET_ENTRY_COUNT;
	logic [TRIM_W-1:0]       digit_limit = RESET_DIGIT_LENGTH;

	function automatic rank_answer_t rank_of_trimmed(input logic [RANK_W-1:0] k,
		input logic [TRIM_W-1:0] trim);
		rank_answer_t     ans;
		logic [BCD_W-1:0] keep;
		logic [BCD_W-1:0] vi;
		logic [BCD_W-1:0] vj;
		int               span;
		int               digits;
		int               below;
		ans.found_index = '0;
		ans.status = ST_RANGE;
		span = (entry_limit > DEFAULT_MAX_ENTRIES) ? DEFAULT_MAX_ENTRIES : int'(entry_limit);
		digits = (digit_limit > DEFAULT_MAX_DIGITS) ? DEFAULT_MAX_DIGITS : int'(digit_limit);
		if (k == 0 || int'(k) > span || trim == 0 || int'(trim) > digits)
			return ans;
		keep = (int'(trim) >= DEFAULT_MAX_DIGITS) ? '1 :
			(64'd1 << (4 * int'(trim))) - 64'd1;
		for (int i = 0; i < span; i++) begin
			vi = slot_word[i] & keep;
			below = 0;
			for (int j = 0; j < span; j++) begin
				vj = slot_word[j] & keep;
				if (vj < vi || (vj == vi && j < i))
					below++;
			end
			if (below == int'(k) - 1) begin
				ans.found_index = SLOT_W'(i);
				ans.status = ST_OK;
				return ans;
			end
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rank_answer_t want;
		if (!arst_n) begin
			entry_limit = RESET_ENTRY_COUNT;
			digit_limit = RESET_DIGIT_LENGTH;
			owed_answers.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ENTRY_COUNT: begin
						entry_limit = cfg.data;
					end
					CFG_DIGIT_LENGTH: begin
						digit_limit = cfg.data[TRIM_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (owed_answers.size() == 0) begin
					$error("response word with no query owed: found_index %0d status %0d",
						rsp.found_index, rsp.status);
					fail_count++;
				end else begin
					want = owed_answers.pop_front();
					if (rsp.found_index !== want.found_index) begin
						$error("found_index mismatch: expected %0d, got %0d",
							want.found_index, rsp.found_index);
						fail_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.status, rsp.status);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.cmd == CMD_LOAD) begin
					slot_word[req.entry_index] = req.bcd_digits;
				end else begin
					owed_answers = {owed_answers,
						rank_of_trimmed(req.rank_k, req.trim_width)};
				end
			end
		end
		pending = owed_answers.size();
	end

endmodule

// ----- tb/kth_smallest_trimmed_select_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// kth_smallest_trimmed_select_tb
// Loads the number table and asks rank queries through the request channel,
// with random gaps and response stalls, over a series of register settings
// that includes the extremes and out of range values. A checker beside the
// block predicts every answer; this module drives stimulus and reports.
// -----------------------------------------------------------------------------
module kth_smallest_trimmed_select_tb;
	import kss_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int SLOTS = DEFAULT_MAX_ENTRIES;
	localparam int PHASES = 11;
	localparam int ITEMS_PER_PHASE = 6;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   no_idle = 1'b0;
	bit   hold_rsp = 1'b0;
	bit   hold_done = 1'b0;
	bit   loaded [SLOTS];
	int   cur_count = RESET_ENTRY_COUNT;
	int   cur_dlen = RESET_DIGIT_LENGTH;
	int   fail_count;
	int   owed;

	kss_cfg_if cfg_if ();
	kss_req_if req_if ();
	kss_rsp_if rsp_if ();

	kth_smallest_trimmed_select u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	kss_rank_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_if),
		.req        (req_if),
		.rsp        (rsp_if),
		.fail_count (fail_count),
		.pending    (owed)
	);

	always #5 clk = ~clk;

	initial begin
		#40_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int live_count();
		return (cur_count > SLOTS) ? SLOTS : cur_count;
	endfunction

	function automatic int live_digits();
		return (cur_dlen > DEFAULT_MAX_DIGITS) ? DEFAULT_MAX_DIGITS : cur_dlen;
	endfunction

	function automatic logic [BCD_W-1:0] pick_word();
		logic [BCD_W-1:0] w;
		int               style;
		w = {$urandom, $urandom};
		style = $urandom_range(0, 2);
		for (int n = 0; n < BCD_W / 4; n++) begin
			if (style == 1)
				w[4*n +: 4] = $urandom_range(0, 2);
			else if (style == 2)
				w[4*n +: 4] = $urandom_range(0, 9);
		end
		return w;
	endfunction

	task automatic offer(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
		input logic [BCD_W-1:0] w, input logic [RANK_W-1:0] k,
		input logic [TRIM_W-1:0] t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.cmd <= c;
		req_if.entry_index <= s;
		req_if.bcd_digits <= w;
		req_if.rank_k <= k;
		req_if.trim_width <= t;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
		@(negedge clk);
		if (c == CMD_LOAD)
			loaded[s] = 1'b1;
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		wait (owed == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_if.index <= idx;
		cfg_if.data <= val;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		if (idx == CFG_ENTRY_COUNT)
			cur_count = val;
		else if (idx == CFG_DIGIT_LENGTH)
			cur_dlen = val[TRIM_W-1:0];
		@(negedge clk);
	endtask

	initial begin : rsp_sink
		int lull;
		bit took;
		lull = 0;
		took = 1'b0;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (took)
				lull = no_idle ? 0 : $urandom_range(0, 3);
			if (hold_rsp && !hold_done) begin
				lull = LONG_HOLD;
				hold_done = 1'b1;
			end
			rsp_if.ready <= (lull == 0);
			if (lull > 0)
				lull--;
			@(posedge clk);
			took = rsp_if.valid && rsp_if.ready;
		end
	end

	initial begin : stimulus
		logic [SLOT_W-1:0] s;
		logic [RANK_W-1:0] k;
		logic [TRIM_W-1:0] t;
		int                n_count;
		int                n_dlen;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_LOAD;
		req_if.entry_index = '0;
		req_if.bcd_digits = '0;
		req_if.rank_k = '0;
		req_if.trim_width = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_ENTRY_COUNT;
		cfg_if.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: one entry, sixteen digits
		offer(CMD_LOAD, 6'd0, 64'h0000_0000_0000_0000, 7'd0, 5'd0);
		offer(CMD_LOAD, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 5'd31);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd1, 5'd16);
		offer(CMD_QUERY, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 5'd1);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd2, 5'd1);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd1, 5'd0);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd127, 5'd31);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd1, 5'd17);
		settle();
		write_reg(CFG_ENTRY_COUNT, 7'd4);

		// ties on the low digit, non-decimal nibbles, full width
		offer(CMD_LOAD, 6'd1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 5'd0);
		offer(CMD_LOAD, 6'd2, 64'h0000_0000_0000_0010, 7'd0, 5'd0);
		offer(CMD_LOAD, 6'd3, 64'h1234_5678_9ABC_DEF0, 7'd0, 5'd0);
		for (int i = 1; i <= 4; i++)
			offer(CMD_QUERY, 6'd0, 64'd0, RANK_W'(i), 5'd1);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd4, 5'd16);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd2, 5'd2);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd3, 5'd15);
		settle();
		write_reg(CFG_DIGIT_LENGTH, 7'd3);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd1, 5'd4);
		offer(CMD_QUERY, 6'd0, 64'd0, 7'd2, 5'd3);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin n_count = 8; n_dlen = 16; end
				1: begin n_count = 3; n_dlen = 2; end
				2: begin n_count = 1; n_dlen = 1; end
				3: begin n_count = 0; n_dlen = 5; end
				4: begin n_count = 16; n_dlen = 31; end
				5: begin n_count = 64; n_dlen = 16; end
				6: begin n_count = 6; n_dlen = 0; end
				7: begin n_count = 127; n_dlen = 4; end
				8: begin n_count = 5; n_dlen = 35; end
				9: begin n_count = 2; n_dlen = 9; end
				default: begin n_count = 12; n_dlen = 16; end
			endcase
			write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(n_count));
			write_reg(CFG_DIGIT_LENGTH, CFG_DATA_W'(n_dlen));
			if (ph == 4)
				write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 127)));
			no_idle = (ph % 4 == 2);

			// fill every slot that a query may read
			for (int i = 0; i < live_count(); i++) begin
				if (!loaded[i])
					offer(CMD_LOAD, SLOT_W'(i), pick_word(), RANK_W'($urandom),
						TRIM_W'($urandom));
			end

			if (ph == 1)
				hold_rsp = 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				if (ph != 1 && $urandom_range(0, 99) < 45) begin
					if (live_count() == 0 || $urandom_range(0, 4) == 0)
						s = $urandom_range(0, SLOTS - 1);
					else
						s = $urandom_range(0, live_count() - 1);
					offer(CMD_LOAD, s, pick_word(), RANK_W'($urandom), TRIM_W'($urandom));
				end else if ($urandom_range(0, 9) < 8) begin
					k = (live_count() == 0) ? RANK_W'($urandom_range(0, 3)) :
						RANK_W'($urandom_range(1, live_count()));
					t = (live_digits() == 0) ? TRIM_W'($urandom_range(0, 3)) :
						TRIM_W'($urandom_range(1, live_digits()));
					offer(CMD_QUERY, SLOT_W'($urandom), {$urandom, $urandom}, k, t);
				end else begin
					offer(CMD_QUERY, SLOT_W'($urandom), {$urandom, $urandom},
						RANK_W'($urandom_range(0, 127)), TRIM_W'($urandom_range(0, 31)));
				end
			end
			settle();
		end

		repeat (20) @(negedge clk);
		if (fail_count == 0 && owed == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
sv/kss_pkg.sv
sv/kss_if.sv
sv/kss_ram.sv
sv/kth_smallest_trimmed_select.sv
tb/kss_rank_checker.sv
tb/kth_smallest_trimmed_select_tb.sv
